>>> rtl/cfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared types, constants and the CRC16 byte update for the frame checker.
// ----------------------------------------------------------------------------
package cfc_pkg;

    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] COUNT_MAX  = 6'd63;
    localparam logic [7:0]       FRAME_HEAD = 8'hA5;
    localparam logic [7:0]       FRAME_TAIL = 8'hD5;
    localparam logic [15:0]      CRC_POLY   = 16'h1021;

    // status codes
    localparam logic [2:0] ST_OK  = 3'd0;
    localparam logic [2:0] ST_HDR = 3'd1;
    localparam logic [2:0] ST_LEN = 3'd2;
    localparam logic [2:0] ST_CRC = 3'd3;
    localparam logic [2:0] ST_OVF = 3'd4;

    // one finished frame, handed from front to back
    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       unit_type;
        logic [7:0]       module_code;
        logic [7:0]       command_code;
        logic [CNT_W-1:0] npay;
    } cfc_job_t;

    // payload store write port
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } cfc_wr_t;

    // CRC16-XMODEM, MSB first, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/cfc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_in_if
// Received byte channel: one word is one UART byte plus its end-of-frame flag.
// ----------------------------------------------------------------------------
interface cfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface
`default_nettype wire

>>> rtl/cfc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_out_if
// Result channel: one word is a frame status or one payload byte.
// ----------------------------------------------------------------------------
interface cfc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] unit_type;
    logic [7:0] module_code;
    logic [7:0] command_code;
    logic [7:0] payload_byte;
    logic       is_payload;
    logic       run_last;

    modport source (output valid, output status, output unit_type,
                    output module_code, output command_code, output payload_byte,
                    output is_payload, output run_last, input ready);
    modport sink   (input valid, input status, input unit_type,
                    input module_code, input command_code, input payload_byte,
                    input is_payload, input run_last, output ready);
endinterface
`default_nettype wire

>>> rtl/cfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_front
// Parses incoming bytes, runs the CRC, writes payload to the store and
// classifies each frame at its last byte.
// ----------------------------------------------------------------------------
module cfc_front #(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    cfc_in_if.sink            din,
    input  logic              q_full,
    output logic              q_push,
    output cfc_pkg::cfc_job_t q_job,
    output cfc_pkg::cfc_wr_t  st_wr,
    input  logic              drain_done
);
    import cfc_pkg::*;

    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             ovf_reg,  ovf_next;
    logic [7:0]       head_reg, head_next;
    logic [15:0]      len_reg,  len_next;
    logic [2:0][7:0]  fld_reg,  fld_next;
    logic [2:0][7:0]  win_reg,  win_next;   // [0] is oldest
    logic [15:0]      crc_reg,  crc_next;
    logic             busy_reg;             // store holds payload not yet drained

    logic [CNT_W-1:0] pos;
    logic             wr_needed;
    logic             accept;
    logic [15:0]      rx_crc;

    assign pos       = cnt_reg - 6'd9;
    assign wr_needed = (cnt_reg >= 6'd9) && ({1'b0, pos} < 7'(PAYLOAD_MAX));
    assign din.ready = !q_full && !(busy_reg && wr_needed);
    assign accept    = din.valid && din.ready;
    assign rx_crc    = {win_reg[1], win_reg[2]};

    always_comb
    begin
        ovf_next  = ovf_reg | (cnt_reg == COUNT_MAX);
        head_next = head_reg;
        len_next  = len_reg;
        fld_next  = fld_reg;
        crc_next  = crc_reg;
        st_wr     = '0;

        case (cnt_reg)
            6'd0:
            begin
                head_next = din.rx_byte;
                fld_next  = '0;
            end
            6'd1:    len_next[15:8] = din.rx_byte;
            6'd2:    len_next[7:0]  = din.rx_byte;
            6'd3:    fld_next[0]    = din.rx_byte;
            6'd4:    fld_next[1]    = din.rx_byte;
            6'd5:    fld_next[2]    = din.rx_byte;
            default: ;
        endcase

        if (cnt_reg >= 6'd3)
            crc_next = crc_feed(crc_reg, win_reg[0]);
        if (cnt_reg >= 6'd9)
        begin
            if (wr_needed)
            begin
                st_wr.en   = accept;
                st_wr.addr = pos;
                st_wr.data = win_reg[0];
            end
            else
                ovf_next = 1'b1;
        end

        win_next = {din.rx_byte, win_reg[2], win_reg[1]};
        cnt_next = (cnt_reg < COUNT_MAX) ? cnt_reg + 6'd1 : cnt_reg;

        q_job.unit_type    = fld_next[0];
        q_job.module_code  = fld_next[1];
        q_job.command_code = fld_next[2];
        q_job.npay         = '0;
        if (head_next != FRAME_HEAD || din.rx_byte != FRAME_TAIL)
            q_job.status = ST_HDR;
        else if (ovf_next)
            q_job.status = ST_OVF;
        else if (cnt_reg < 6'd8 || (17'(len_next) + 17'd3) != (17'(cnt_reg) + 17'd1))
            q_job.status = ST_LEN;
        else if (rx_crc != crc_next)
            q_job.status = ST_CRC;
        else
        begin
            q_job.status = ST_OK;
            q_job.npay   = cnt_reg - 6'd8;
        end
    end

    assign q_push = accept && din.frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            head_reg <= '0;
            len_reg  <= '0;
            fld_reg  <= '0;
            win_reg  <= '0;
            crc_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (din.frame_end)
                begin
                    cnt_reg  <= '0;
                    ovf_reg  <= 1'b0;
                    head_reg <= '0;
                    len_reg  <= '0;
                    fld_reg  <= '0;
                    win_reg  <= '0;
                    crc_reg  <= '0;
                end
                else
                begin
                    cnt_reg  <= cnt_next;
                    ovf_reg  <= ovf_next;
                    head_reg <= head_next;
                    len_reg  <= len_next;
                    fld_reg  <= fld_next;
                    win_reg  <= win_next;
                    crc_reg  <= crc_next;
                end
            end

            if (q_push && q_job.npay != '0)
                busy_reg <= 1'b1;
            else if (drain_done)
                busy_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

>>> rtl/cfc_jobq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_jobq
// Two-entry queue of classified frames between front and back.
// ----------------------------------------------------------------------------
module cfc_jobq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cfc_pkg::cfc_job_t push_job,
    output logic              full,
    input  logic              pop,
    output cfc_pkg::cfc_job_t pop_job,
    output logic              not_empty
);
    import cfc_pkg::*;

    cfc_job_t   ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_job   = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

>>> rtl/cfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfc_back
// Holds the payload store; emits the status word of each frame and then
// its payload bytes through a registered output.
// ----------------------------------------------------------------------------
module cfc_back #(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfc_pkg::cfc_job_t job,
    input  logic              job_valid,
    output logic              job_pop,
    input  cfc_pkg::cfc_wr_t  st_wr,
    output logic              drain_done,
    cfc_out_if.source         dout
);
    import cfc_pkg::*;

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_SEND = 3'b100
    } back_state_t;

    back_state_t      state_reg, state_next;
    logic [7:0]       store [PAYLOAD_MAX];
    logic [7:0]       rd_data_reg;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0] npay_reg, npay_next;

    logic             ovalid_reg, ovalid_next;
    logic [2:0]       status_reg;
    logic [7:0]       type_reg, mod_reg, cmd_reg, pay_reg;
    logic             isp_reg, last_reg;

    logic             out_load;
    logic             load_stat;
    logic             load_pay;
    logic             pay_last;

    assign out_load = !ovalid_reg || dout.ready;
    assign pay_last = ((CNT_W'(idx_reg) + 6'd1) == npay_reg);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        npay_next   = npay_reg;
        load_stat   = 1'b0;
        load_pay    = 1'b0;
        drain_done  = 1'b0;
        ovalid_next = ovalid_reg && !dout.ready;

        case (state_reg)
            B_IDLE:
            begin
                if (job_valid && out_load)
                begin
                    load_stat = 1'b1;
                    if (job.npay != '0)
                    begin
                        npay_next  = job.npay;
                        idx_next   = '0;
                        state_next = B_READ;
                    end
                end
            end
            B_READ:  state_next = B_SEND;
            B_SEND:
            begin
                if (out_load)
                begin
                    load_pay = 1'b1;
                    if (pay_last)
                    begin
                        drain_done = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_READ;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase

        if (load_stat || load_pay)
            ovalid_next = 1'b1;
    end

    assign job_pop = load_stat;

    always_ff @(posedge clk)
    begin
        if (st_wr.en)
            store[st_wr.addr[AW-1:0]] <= st_wr.data;
        if (state_reg == B_READ)
            rd_data_reg <= store[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load_stat)
        begin
            status_reg <= job.status;
            type_reg   <= job.unit_type;
            mod_reg    <= job.module_code;
            cmd_reg    <= job.command_code;
            pay_reg    <= '0;
            isp_reg    <= 1'b0;
            last_reg   <= (job.npay == '0);
        end
        else if (load_pay)
        begin
            status_reg <= ST_OK;
            type_reg   <= '0;
            mod_reg    <= '0;
            cmd_reg    <= '0;
            pay_reg    <= rd_data_reg;
            isp_reg    <= 1'b1;
            last_reg   <= pay_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            idx_reg    <= '0;
            npay_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            npay_reg   <= npay_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign dout.valid        = ovalid_reg;
    assign dout.status       = status_reg;
    assign dout.unit_type    = type_reg;
    assign dout.module_code  = mod_reg;
    assign dout.command_code = cmd_reg;
    assign dout.payload_byte = pay_reg;
    assign dout.is_payload   = isp_reg;
    assign dout.run_last     = last_reg;

endmodule
`default_nettype wire

>>> rtl/crc16_frame_checker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_checker_core
// Framed packet receiver: header/length/CRC16-XMODEM/tail checks with a
// status word per frame followed by the buffered payload on success.
// ----------------------------------------------------------------------------
//
//  channel | dir | word contents                                   | accepted when
//  --------+-----+-------------------------------------------------+--------------------
//  din     | in  | rx_byte, frame_end                              | valid && ready
//  dout    | out | status, unit_type, module_code,                 | valid && ready
//          |     | command_code, payload_byte, is_payload, run_last|
//
//  - din takes one byte per cycle while din.ready is high; the front updates the
//    CRC one byte per cycle and classifies the frame on the byte carrying frame_end.
//  - The status word passes through the job queue and the output register after
//    the frame-end byte is taken when the back is idle; otherwise it waits behind
//    earlier frames' words. Payload bytes follow one at a time: each is read from
//    the payload store into a register before it is loaded into the output register.
//  - din.ready drops while the job queue is full, and for a byte that would
//    write the payload store while an earlier frame's payload is still
//    queued or draining.
//  - rst_n clears all control and frame state at once; the payload store is
//    not cleared (only entries written by the current frame are read).
//
// ----------------------------------------------------------------------------
module crc16_frame_checker_core #(
    parameter int PAYLOAD_MAX = 32   // 1..63; a frame carries at most 54 payload bytes
) (
    input  logic      clk,
    input  logic      rst_n,
    cfc_in_if.sink    din,
    cfc_out_if.source dout
);
    import cfc_pkg::*;

    // front -> queue
    logic     q_push;
    logic     q_full;
    cfc_job_t q_job_in;

    // queue -> back
    logic     q_pop;
    logic     q_not_empty;
    cfc_job_t q_job_out;

    // store write port and drain handshake between front and back
    cfc_wr_t  st_wr;
    logic     drain_done;

    // Front: parse, CRC, payload capture, classification at frame end
    cfc_front #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_job_in),
        .st_wr      (st_wr),
        .drain_done (drain_done)
    );

    // Short queue of finished frames so either side can stall alone
    cfc_jobq u_jobq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_job_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_job   (q_job_out),
        .not_empty (q_not_empty)
    );

    // Back: status word, then payload bytes from the store
    cfc_back #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (q_job_out),
        .job_valid  (q_not_empty),
        .job_pop    (q_pop),
        .st_wr      (st_wr),
        .drain_done (drain_done),
        .dout       (dout)
    );

endmodule
`default_nettype wire
